[hw/rtl/ps2dec_pkg.sv]
// ----------------------------------------------------------------------------
// ps2dec_pkg
// Constants and lookup functions for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
package ps2dec_pkg;

  localparam int unsigned ScanW  = 8;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned ModW   = 3;
  localparam int unsigned AsciiW = 7;
  localparam int unsigned OutW   = 32;

  localparam logic [ScanW-1:0] PfxExt  = 8'hE0;
  localparam int unsigned      RelBit  = 7;

  localparam logic [KeyW-1:0] KeyLShift = 7'd42;
  localparam logic [KeyW-1:0] KeyRShift = 7'd54;
  localparam logic [KeyW-1:0] KeyLCtrl  = 7'd29;
  localparam logic [KeyW-1:0] KeyRCtrl  = 7'd97;
  localparam logic [KeyW-1:0] KeyRAlt   = 7'd100;

  localparam int unsigned ModShift = 0;
  localparam int unsigned ModCtrl  = 1;
  localparam int unsigned ModAltGr = 2;

  // key code for a plain (non-prefixed) scancode
  function automatic logic [KeyW-1:0] base_key(input logic [CodeW-1:0] c);
    logic [KeyW-1:0] k;
    k = c;
    if (c == 7'h00 || c > 7'h58) begin
      k = '0;
    end else begin
      unique case (c)
        7'h0C, 7'h0D, 7'h1A, 7'h1B, 7'h27,
        7'h28, 7'h29, 7'h2B, 7'h54, 7'h55: k = '0;
        default: k = c;
      endcase
    end
    return k;
  endfunction

  // key code for a scancode that followed the extended prefix
  function automatic logic [KeyW-1:0] ext_key(input logic [CodeW-1:0] c);
    logic [KeyW-1:0] k;
    unique case (c)
      7'h1D:   k = KeyRCtrl;
      7'h38:   k = KeyRAlt;
      7'h47:   k = 7'd102;
      7'h48:   k = 7'd103;
      7'h49:   k = 7'd104;
      7'h4B:   k = 7'd105;
      7'h4D:   k = 7'd106;
      7'h4F:   k = 7'd107;
      7'h50:   k = 7'd108;
      7'h51:   k = 7'd109;
      7'h52:   k = 7'd110;
      7'h53:   k = 7'd111;
      7'h5B:   k = 7'd125;
      7'h5C:   k = 7'd126;
      7'h5D:   k = 7'd127;
      default: k = '0;
    endcase
    return k;
  endfunction

  // swiss german keymap rom, returns {shifted, unshifted}
  function automatic logic [2*AsciiW-1:0] keymap(input logic [CodeW-1:0] c);
    logic [2*AsciiW-1:0] r;
    unique case (c)
      7'h01:   r = {7'h1B, 7'h1B};
      7'h02:   r = {7'h2B, 7'h31};
      7'h03:   r = {7'h22, 7'h32};
      7'h04:   r = {7'h2A, 7'h33};
      7'h05:   r = {7'h00, 7'h34};
      7'h06:   r = {7'h25, 7'h35};
      7'h07:   r = {7'h26, 7'h36};
      7'h08:   r = {7'h2F, 7'h37};
      7'h09:   r = {7'h28, 7'h38};
      7'h0A:   r = {7'h29, 7'h39};
      7'h0B:   r = {7'h3D, 7'h30};
      7'h0C:   r = {7'h3F, 7'h27};
      7'h0D:   r = {7'h60, 7'h5E};
      7'h0E:   r = {7'h08, 7'h08};
      7'h0F:   r = {7'h09, 7'h09};
      7'h10:   r = {7'h51, 7'h71};
      7'h11:   r = {7'h57, 7'h77};
      7'h12:   r = {7'h45, 7'h65};
      7'h13:   r = {7'h52, 7'h72};
      7'h14:   r = {7'h54, 7'h74};
      7'h15:   r = {7'h5A, 7'h7A};
      7'h16:   r = {7'h55, 7'h75};
      7'h17:   r = {7'h49, 7'h69};
      7'h18:   r = {7'h4F, 7'h6F};
      7'h19:   r = {7'h50, 7'h70};
      7'h1B:   r = {7'h00, 7'h21};
      7'h1C:   r = {7'h0A, 7'h0A};
      7'h1E:   r = {7'h41, 7'h61};
      7'h1F:   r = {7'h53, 7'h73};
      7'h20:   r = {7'h44, 7'h64};
      7'h21:   r = {7'h46, 7'h66};
      7'h22:   r = {7'h47, 7'h67};
      7'h23:   r = {7'h48, 7'h68};
      7'h24:   r = {7'h4A, 7'h6A};
      7'h25:   r = {7'h4B, 7'h6B};
      7'h26:   r = {7'h4C, 7'h6C};
      7'h2B:   r = {7'h23, 7'h24};
      7'h2C:   r = {7'h59, 7'h79};
      7'h2D:   r = {7'h58, 7'h78};
      7'h2E:   r = {7'h43, 7'h63};
      7'h2F:   r = {7'h56, 7'h76};
      7'h30:   r = {7'h42, 7'h62};
      7'h31:   r = {7'h4E, 7'h6E};
      7'h32:   r = {7'h4D, 7'h6D};
      7'h33:   r = {7'h3B, 7'h2C};
      7'h34:   r = {7'h3A, 7'h2E};
      7'h35:   r = {7'h5F, 7'h2D};
      7'h37:   r = {7'h2A, 7'h2A};
      7'h39:   r = {7'h20, 7'h20};
      7'h47:   r = {7'h00, 7'h37};
      7'h48:   r = {7'h00, 7'h38};
      7'h49:   r = {7'h00, 7'h39};
      7'h4A:   r = {7'h00, 7'h2D};
      7'h4B:   r = {7'h00, 7'h34};
      7'h4C:   r = {7'h00, 7'h35};
      7'h4D:   r = {7'h00, 7'h36};
      7'h4E:   r = {7'h00, 7'h2B};
      7'h4F:   r = {7'h00, 7'h31};
      7'h50:   r = {7'h00, 7'h32};
      7'h51:   r = {7'h00, 7'h33};
      7'h52:   r = {7'h00, 7'h30};
      7'h53:   r = {7'h00, 7'h2E};
      7'h56:   r = {7'h3E, 7'h3C};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/ps2_set1_scancode_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder
// Decodes set-1 scancode bytes into key events with modifiers and ascii.
// ----------------------------------------------------------------------------
// a byte is held in the input register, then its event in the result register
// one byte per cycle unless the output stalls; the held-key flags form a loop
// an extended prefix byte is consumed and gives no event
// reset clears both pipeline valids, the prefix flag and all held flags
module ps2_set1_scancode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] scan_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [7:0] raw_byte, [14:8] key_code,
                                        // [15] is_press, [18:16] modifier_mask,
                                        // [25:19] ascii_char, [31:26] zero
);

  logic                          in_valid_q;
  logic [ps2dec_pkg::ScanW-1:0]  in_byte_q;
  logic                          out_valid_q;
  logic [ps2dec_pkg::OutW-1:0]   out_data_q;
  logic [ps2dec_pkg::OutW-1:0]   out_data_d;
  logic ext_q, ext_d, shift_q, shift_d, ctrl_q, ctrl_d, altgr_q, altgr_d;

  logic                           is_pfx, out_free, advance, emit, press;
  logic [ps2dec_pkg::CodeW-1:0]   code;
  logic [ps2dec_pkg::KeyW-1:0]    key;
  logic [ps2dec_pkg::ModW-1:0]    mods;
  logic [2*ps2dec_pkg::AsciiW-1:0] map_pair;
  logic [ps2dec_pkg::AsciiW-1:0]  glyph, ascii;

  assign is_pfx   = (in_byte_q == ps2dec_pkg::PfxExt);
  assign out_free = !out_valid_q || m_axis_tready_i;
  // a prefix byte needs no room downstream
  assign advance  = in_valid_q && (is_pfx || out_free);
  assign emit     = advance && !is_pfx;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    press = !in_byte_q[ps2dec_pkg::RelBit];
    code  = in_byte_q[ps2dec_pkg::CodeW-1:0];
    key   = ext_q ? ps2dec_pkg::ext_key(code) : ps2dec_pkg::base_key(code);

    ext_d   = ext_q;
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    altgr_d = altgr_q;
    if (advance) begin
      ext_d = is_pfx;
      if (!is_pfx) begin
        if (key == ps2dec_pkg::KeyLShift || key == ps2dec_pkg::KeyRShift) begin
          shift_d = press;
        end else if (key == ps2dec_pkg::KeyLCtrl || key == ps2dec_pkg::KeyRCtrl) begin
          ctrl_d = press;
        end else if (key == ps2dec_pkg::KeyRAlt) begin
          altgr_d = press;
        end
      end
    end

    mods = '0;
    mods[ps2dec_pkg::ModShift] = shift_d;
    mods[ps2dec_pkg::ModCtrl]  = ctrl_d;
    mods[ps2dec_pkg::ModAltGr] = altgr_d;

    map_pair = ps2dec_pkg::keymap(code);
    glyph    = shift_d ? map_pair[2*ps2dec_pkg::AsciiW-1:ps2dec_pkg::AsciiW]
                       : map_pair[ps2dec_pkg::AsciiW-1:0];
    ascii = '0;
    if (!ext_q && press) begin
      // ctrl folds letters onto 1..26
      priority if (ctrl_d && glyph >= 7'h61 && glyph <= 7'h7A) begin
        ascii = glyph - 7'h60;
      end else if (ctrl_d && glyph >= 7'h41 && glyph <= 7'h5A) begin
        ascii = glyph - 7'h40;
      end else begin
        ascii = glyph;
      end
    end

    out_data_d = {6'b0, ascii, mods, press, key, in_byte_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ext_q       <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      altgr_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
      ext_q   <= ext_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      altgr_q <= altgr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_pfx_sets_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_pfx |=> ext_q)
    else $error("prefix byte did not set extended flag");

  a_ascii_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[25:19] != 7'd0 |-> out_data_q[15])
    else $error("ascii given on release");

  a_shift_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q[14:8] == ps2dec_pkg::KeyLShift ||
                    out_data_q[14:8] == ps2dec_pkg::KeyRShift)
    |-> out_data_q[16 + ps2dec_pkg::ModShift] == out_data_q[15])
    else $error("shift flag does not follow shift key");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && !is_pfx && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a downstream stall");

endmodule

[sim/tb_ps2_set1_scancode_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ps2_set1_scancode_decoder
// Drives set-1 scancode bytes into the decoder through the input stream. A
// local key model predicts the event for every accepted non-prefix byte: key
// code, press bit, held modifiers and the keymap character. Each output transfer is
// checked field by field against the oldest predicted event. Both stream
// sides insert random gaps, and one stretch of traffic runs without any.
// ----------------------------------------------------------------------------
module tb_ps2_set1_scancode_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]                    pad;
    logic [ps2dec_pkg::AsciiW-1:0] ascii;
    logic [ps2dec_pkg::ModW-1:0]   mods;
    logic                          press;
    logic [ps2dec_pkg::KeyW-1:0]   key;
    logic [ps2dec_pkg::ScanW-1:0]  raw;
  } key_event_t;

  localparam logic [ps2dec_pkg::ScanW-1:0] RelMask  = 8'h80;
  localparam logic [ps2dec_pkg::ScanW-1:0] ScLShift = 8'h2A;
  localparam logic [ps2dec_pkg::ScanW-1:0] ScRShift = 8'h36;
  // left ctrl, right ctrl after prefix
  localparam logic [ps2dec_pkg::ScanW-1:0] ScCtrl   = 8'h1D;
  // left alt, AltGr after prefix
  localparam logic [ps2dec_pkg::ScanW-1:0] ScAlt    = 8'h38;
  localparam logic [ps2dec_pkg::ScanW-1:0] ScPfxE1  = 8'hE1;
  localparam int unsigned                  GlyphCnt = 88;

  // keymap glyphs per base code, without and with shift
  localparam logic [ps2dec_pkg::AsciiW-1:0] GlyphPlain [0:GlyphCnt-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h27, 7'h5E, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h7A, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h00, 7'h21, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h24, 7'h79, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2D, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h3C, 7'h00
  };
  localparam logic [ps2dec_pkg::AsciiW-1:0] GlyphShift [0:GlyphCnt-1] = '{
    7'h00, 7'h1B, 7'h2B, 7'h22, 7'h2A, 7'h00, 7'h25, 7'h26,
    7'h2F, 7'h28, 7'h29, 7'h3D, 7'h3F, 7'h60, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h5A, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h00, 7'h00, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h23, 7'h59, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3B, 7'h3A, 7'h5F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h3E, 7'h00
  };

  // codes that have an entry in the extended table
  localparam logic [ps2dec_pkg::CodeW-1:0] ExtCodes [0:14] = '{
    7'h1D, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D, 7'h4F,
    7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C, 7'h5D
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [ps2dec_pkg::ScanW-1:0] s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [ps2dec_pkg::OutW-1:0]  m_tdata;

  key_event_t  pending_events[$];
  int unsigned n_errors = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  // key model state
  bit ext_armed = 1'b0;
  bit shift_on = 1'b0;
  bit ctrl_on = 1'b0;
  bit altgr_on = 1'b0;

  ps2_set1_scancode_decoder i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ps2dec_pkg::KeyW-1:0] plain_key_of(
      input logic [ps2dec_pkg::CodeW-1:0] c);
    if (c == 7'h00 || c > 7'h58) begin
      return '0;
    end
    case (c)
      7'h0C, 7'h0D, 7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29, 7'h2B, 7'h54, 7'h55: return '0;
      default: return c;
    endcase
  endfunction

  function automatic logic [ps2dec_pkg::KeyW-1:0] ext_key_of(
      input logic [ps2dec_pkg::CodeW-1:0] c);
    case (c)
      7'h1D:   return ps2dec_pkg::KeyRCtrl;
      7'h38:   return ps2dec_pkg::KeyRAlt;
      7'h5B:   return 7'd125;
      7'h5C:   return 7'd126;
      7'h5D:   return 7'd127;
      7'h47, 7'h48, 7'h49: return c + 7'd31;
      7'h4B:   return 7'd105;
      7'h4D:   return 7'd106;
      7'h4F, 7'h50, 7'h51, 7'h52, 7'h53: return c + 7'd28;
      default: return '0;
    endcase
  endfunction

  // applies one accepted byte to the key model and, unless it is the prefix, queues its event
  function automatic void predict_byte(input logic [ps2dec_pkg::ScanW-1:0] b);
    key_event_t                    ev;
    logic [ps2dec_pkg::CodeW-1:0]  c;
    logic [ps2dec_pkg::AsciiW-1:0] g;
    bit                            was_ext;
    if (b == ps2dec_pkg::PfxExt) begin
      ext_armed = 1'b1;
      return;
    end
    ev = '0;
    ev.raw = b;
    ev.press = !b[ps2dec_pkg::RelBit];
    c = b[ps2dec_pkg::CodeW-1:0];
    was_ext = ext_armed;
    ext_armed = 1'b0;
    ev.key = was_ext ? ext_key_of(c) : plain_key_of(c);
    if (ev.key == ps2dec_pkg::KeyLShift || ev.key == ps2dec_pkg::KeyRShift) begin
      shift_on = ev.press;
    end else if (ev.key == ps2dec_pkg::KeyLCtrl || ev.key == ps2dec_pkg::KeyRCtrl) begin
      ctrl_on = ev.press;
    end else if (ev.key == ps2dec_pkg::KeyRAlt) begin
      altgr_on = ev.press;
    end
    ev.mods[ps2dec_pkg::ModShift] = shift_on;
    ev.mods[ps2dec_pkg::ModCtrl]  = ctrl_on;
    ev.mods[ps2dec_pkg::ModAltGr] = altgr_on;
    if (!was_ext && ev.press && c < GlyphCnt) begin
      g = shift_on ? GlyphShift[c] : GlyphPlain[c];
      // ctrl folds letters of either case onto 1..26
      if (ctrl_on && g >= 7'h61 && g <= 7'h7A) begin
        ev.ascii = g - 7'h60;
      end else if (ctrl_on && g >= 7'h41 && g <= 7'h5A) begin
        ev.ascii = g - 7'h40;
      end else begin
        ev.ascii = g;
      end
    end
    pending_events.push_back(ev);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  task automatic send_byte(input logic [ps2dec_pkg::ScanW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do begin
      @(posedge clk);
    end while (!s_tready);
    predict_byte(b);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_events.size() == 0) begin
        report_mismatch("event with none pending", got, '0);
      end else begin
        want = pending_events.pop_front();
        if (got.raw != want.raw) begin
          report_mismatch("raw_byte", 32'(got.raw), 32'(want.raw));
        end
        if (got.key != want.key) begin
          report_mismatch("key_code", 32'(got.key), 32'(want.key));
        end
        if (got.press != want.press) begin
          report_mismatch("is_press", 32'(got.press), 32'(want.press));
        end
        if (got.mods != want.mods) begin
          report_mismatch("modifier_mask", 32'(got.mods), 32'(want.mods));
        end
        if (got.ascii != want.ascii) begin
          report_mismatch("ascii_char", 32'(got.ascii), 32'(want.ascii));
        end
        if (got.pad != '0) report_mismatch("padding", 32'(got.pad), '0);
      end
    end
  end

  task automatic test_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(RelMask);
  endtask

  // repeated prefix, right ctrl and AltGr, unmapped extended code
  task automatic test_prefix();
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(ScCtrl);
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(ScAlt);
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(ScCtrl | RelMask);
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(ScAlt | RelMask);
    send_byte(ps2dec_pkg::PfxExt);
    send_byte(8'h10);
  endtask

  // shift and ctrl on letters, left alt, unmapped code with a glyph, E1 prefix
  task automatic test_modifiers();
    send_byte(ScLShift);
    send_byte(8'h10);
    send_byte(ScCtrl);
    send_byte(8'h10);
    send_byte(ScLShift | RelMask);
    send_byte(ScCtrl | RelMask);
    send_byte(ScRShift);
    send_byte(ScRShift | RelMask);
    send_byte(ScAlt);
    send_byte(8'h0C);
    send_byte(ScPfxE1);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned                  sent;
    int unsigned                  pick;
    logic [ps2dec_pkg::ScanW-1:0] b;
    logic [ps2dec_pkg::ScanW-1:0] rel;
    sent = 0;
    while (sent < n_items) begin
      // one stretch runs back to back on both sides
      quiet = (sent >= n_items / 2 && sent < n_items / 2 + 80);
      pick = $urandom_range(0, 99);
      rel = $urandom_range(0, 1) ? RelMask : '0;
      if (pick < 20) begin
        if ($urandom_range(0, 9) == 0) begin
          b = {1'b0, 7'($urandom_range(0, 127))};
        end else begin
          b = {1'b0, ExtCodes[$urandom_range(0, 14)]};
        end
        send_byte(ps2dec_pkg::PfxExt);
        send_byte(b | rel);
        sent += 2;
      end else if (pick < 35) begin
        case ($urandom_range(0, 4))
          0: b = ScLShift;
          1: b = ScRShift;
          2: b = ScCtrl;
          default: begin
            send_byte(ps2dec_pkg::PfxExt);
            sent++;
            b = $urandom_range(0, 1) ? ScCtrl : ScAlt;
          end
        endcase
        send_byte(b | rel);
        sent++;
      end else if (pick < 80) begin
        b = 8'($urandom_range(1, 8'h58));
        send_byte(b);
        sent++;
        if ($urandom_range(0, 1)) begin
          send_byte(b | RelMask);
          sent++;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_prefix();
    test_modifiers();
    test_random_traffic(520);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0 && pending_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
